### design/lpc_pkg.sv
// ----------------------------------------------------------------------------
// lpc_pkg
// shared types and codes for the lift position controller
// ----------------------------------------------------------------------------
`default_nettype none

package lpc_pkg;

  // item kinds on the input channel
  typedef enum logic [1:0] {
    FUNC_EDGE   = 2'd0,
    FUNC_CMD    = 2'd1,
    FUNC_SENSOR = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  // command characters
  localparam logic [7:0] CMD_UP    = 8'h75;  // 'u'
  localparam logic [7:0] CMD_DOWN  = 8'h64;  // 'd'
  localparam logic [7:0] CMD_CLEAR = 8'h72;  // 'r'

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_TOLERANCE    = 2'd0,
    REG_STEP_SIZE    = 2'd1,
    REG_MAX_SETPOINT = 2'd2,
    REG_UNUSED       = 2'd3
  } reg_idx_t;

  localparam int unsigned TOL_W  = 10;
  localparam int unsigned SP_W   = 16;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned POUT_W = 24;

  // configuration reset values
  localparam logic [TOL_W-1:0] TOL_RST  = 10'd50;
  localparam logic [SP_W-1:0]  STEP_RST = 16'd1000;
  localparam logic [SP_W-1:0]  MAX_RST  = 16'd8000;

  // motor decision for one result
  typedef struct packed {
    logic up;
    logic down;
    logic at_target;
  } drive_t;

endpackage

`default_nettype wire

### design/lift_position_controller.sv
// ----------------------------------------------------------------------------
// lift_position_controller
// bang-bang lift position control with a deadband and homing after reset
// ----------------------------------------------------------------------------
//  channel   ports                                    flow
//  input     in_valid / in_stall, in_func .. sensor   one item per transfer
//  result    out_valid / out_stall, out_drive_up ..   one result per item
//  config    cfg_we, cfg_index, cfg_wdata             write only, no wait
//
// one item per cycle while in_stall is low; an item passes the input register,
// then the state update and deadband compare into the result register, before
// its result is presented. out_stall holds the result register and backs up
// into in_stall only when the input register is also full. reset starts in
// homing with tolerance 50, step 1000 and setpoint limit 8000.
// ----------------------------------------------------------------------------
`default_nettype none

module lift_position_controller
  import lpc_pkg::*;
#(
  parameter int unsigned POSITION_WIDTH = 24
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // input channel
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          in_func,
  input  wire logic                in_enc_b,
  input  wire logic [7:0]          in_cmd_byte,
  input  wire logic                in_bottom_sensor,
  // result channel
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     out_drive_up,
  output logic                     out_drive_down,
  output logic                     out_at_target,
  output logic                     out_homing_active,
  output logic signed [POUT_W-1:0] out_position_now,
  output logic [SP_W-1:0]          out_setpoint_now,
  // configuration
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [CFG_W-1:0]    cfg_wdata
);

  localparam int unsigned EW = (POSITION_WIDTH > POUT_W) ? POSITION_WIDTH : POUT_W;

  logic [TOL_W-1:0] tolerance_r;
  logic [SP_W-1:0]  step_size_r;
  logic [SP_W-1:0]  max_setpoint_r;

  logic             in_valid_r;
  logic [1:0]       func_r;
  logic             enc_b_r;
  logic [7:0]       cmd_byte_r;
  logic             sensor_r;

  logic             out_valid_r;
  drive_t           drive_r;
  logic             homing_out_r;
  logic [POUT_W-1:0] position_out_r;
  logic [SP_W-1:0]  setpoint_out_r;

  logic                             advance;
  logic                             in_xfer;
  logic                             step_en;
  logic                             homing_nxt;
  logic signed [POSITION_WIDTH-1:0] position_nxt;
  logic [SP_W-1:0]                  setpoint_nxt;
  logic signed [EW-1:0]             position_ext;
  drive_t                           drive_nxt;

  // handshake control
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = in_valid_r && !advance;
  assign in_xfer  = in_valid && !in_stall;
  assign step_en  = in_valid_r && advance;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tolerance_r    <= TOL_RST;
      step_size_r    <= STEP_RST;
      max_setpoint_r <= MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TOLERANCE:    tolerance_r    <= cfg_wdata[TOL_W-1:0];
        REG_STEP_SIZE:    step_size_r    <= cfg_wdata[SP_W-1:0];
        REG_MAX_SETPOINT: max_setpoint_r <= cfg_wdata[SP_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_xfer) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      func_r     <= in_func;
      enc_b_r    <= in_enc_b;
      cmd_byte_r <= in_cmd_byte;
      sensor_r   <= in_bottom_sensor;
    end
  end

  // state update
  lpc_state #(
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_state (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (step_en),
    .func         (func_r),
    .enc_b        (enc_b_r),
    .cmd_byte     (cmd_byte_r),
    .bottom_sensor(sensor_r),
    .step_size    (step_size_r),
    .max_setpoint (max_setpoint_r),
    .homing_nxt   (homing_nxt),
    .position_nxt (position_nxt),
    .setpoint_nxt (setpoint_nxt)
  );

  // deadband decision on the updated state
  lpc_band #(
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_band (
    .homing   (homing_nxt),
    .position (position_nxt),
    .setpoint (setpoint_nxt),
    .tolerance(tolerance_r),
    .drive    (drive_nxt)
  );

  assign position_ext = EW'(position_nxt);

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      drive_r        <= drive_nxt;
      homing_out_r   <= homing_nxt;
      position_out_r <= position_ext[POUT_W-1:0];
      setpoint_out_r <= setpoint_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_drive_up      = drive_r.up;
  assign out_drive_down    = drive_r.down;
  assign out_at_target     = drive_r.at_target;
  assign out_homing_active = homing_out_r;
  assign out_position_now  = position_out_r;
  assign out_setpoint_now  = setpoint_out_r;

endmodule

`default_nettype wire

### design/lpc_state.sv
// ----------------------------------------------------------------------------
// lpc_state
// position, setpoint and homing registers with their per-item update
// ----------------------------------------------------------------------------
`default_nettype none

module lpc_state
  import lpc_pkg::*;
#(
  parameter int unsigned POSITION_WIDTH = 24
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             step_en,
  input  wire logic [1:0]                       func,
  input  wire logic                             enc_b,
  input  wire logic [7:0]                       cmd_byte,
  input  wire logic                             bottom_sensor,
  input  wire logic [SP_W-1:0]                  step_size,
  input  wire logic [SP_W-1:0]                  max_setpoint,
  output logic                                  homing_nxt,
  output logic signed [POSITION_WIDTH-1:0]      position_nxt,
  output logic [SP_W-1:0]                       setpoint_nxt
);

  localparam logic signed [POSITION_WIDTH-1:0] POS_MAX =
    {1'b0, {(POSITION_WIDTH-1){1'b1}}};
  localparam logic signed [POSITION_WIDTH-1:0] POS_MIN =
    {1'b1, {(POSITION_WIDTH-1){1'b0}}};

  logic                              homing_r;
  logic signed [POSITION_WIDTH-1:0]  position_r;
  logic [SP_W-1:0]                   setpoint_r;
  logic [SP_W:0]                     sp_sum;

  assign sp_sum = {1'b0, setpoint_r} + {1'b0, step_size};

  // next state for the item held in the input register
  always_comb begin
    homing_nxt   = homing_r;
    position_nxt = position_r;
    setpoint_nxt = setpoint_r;
    if (homing_r) begin
      if (func == FUNC_SENSOR && bottom_sensor) begin
        homing_nxt   = 1'b0;
        position_nxt = '0;
        setpoint_nxt = '0;
      end
    end else begin
      case (func)
        FUNC_EDGE: begin
          if (!enc_b) begin
            if (position_r != POS_MAX) position_nxt = position_r + POSITION_WIDTH'(1);
          end else begin
            if (position_r != POS_MIN) position_nxt = position_r - POSITION_WIDTH'(1);
          end
        end
        FUNC_CMD: begin
          case (cmd_byte)
            CMD_UP: begin
              if (sp_sum >= {1'b0, max_setpoint}) setpoint_nxt = max_setpoint;
              else setpoint_nxt = sp_sum[SP_W-1:0];
            end
            CMD_DOWN: begin
              if (setpoint_r <= step_size) setpoint_nxt = '0;
              else setpoint_nxt = setpoint_r - step_size;
            end
            CMD_CLEAR: setpoint_nxt = '0;
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // state registers, updated once per item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      homing_r   <= 1'b1;
      position_r <= '0;
      setpoint_r <= '0;
    end else if (step_en) begin
      homing_r   <= homing_nxt;
      position_r <= position_nxt;
      setpoint_r <= setpoint_nxt;
    end
  end

endmodule

`default_nettype wire

### design/lpc_band.sv
// ----------------------------------------------------------------------------
// lpc_band
// deadband compare of position against setpoint plus or minus tolerance
// ----------------------------------------------------------------------------
`default_nettype none

module lpc_band
  import lpc_pkg::*;
#(
  parameter int unsigned POSITION_WIDTH = 24
) (
  input  wire logic                             homing,
  input  wire logic signed [POSITION_WIDTH-1:0] position,
  input  wire logic [SP_W-1:0]                  setpoint,
  input  wire logic [TOL_W-1:0]                 tolerance,
  output drive_t                                drive
);

  // compare width covers the position and setpoint plus or minus tolerance
  localparam int unsigned CW = ((POSITION_WIDTH > SP_W + 2) ? POSITION_WIDTH : SP_W + 2) + 1;

  logic signed [CW-1:0] pos_ext;
  logic signed [CW-1:0] lo;
  logic signed [CW-1:0] hi;

  assign pos_ext = CW'(position);
  assign lo = $signed(CW'({1'b0, setpoint})) - $signed(CW'({1'b0, tolerance}));
  assign hi = $signed(CW'({1'b0, setpoint})) + $signed(CW'({1'b0, tolerance}));

  // homing drives down, otherwise up below the band, at_target inside it and down above it
  always_comb begin
    drive = '0;
    if (homing) begin
      drive.down = 1'b1;
    end else if (pos_ext < lo) begin
      drive.up = 1'b1;
    end else if (pos_ext <= hi) begin
      drive.at_target = 1'b1;
    end else begin
      drive.down = 1'b1;
    end
  end

endmodule

`default_nettype wire
